FILE: rtl/bqf_pkg.sv
// Shared constants, register indexes and sequencer step codes of the biquad filter.
package bqf_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int COEF_WIDTH      = 16;
   localparam int COEF_FRAC_BITS  = 14;
   localparam int HIST_WIDTH      = SAMPLE_WIDTH + 8;
   localparam int PROD_WIDTH      = COEF_WIDTH + HIST_WIDTH;
   localparam int ACC_WIDTH       = PROD_WIDTH + 2;
   localparam int Y_WIDTH         = ACC_WIDTH - COEF_FRAC_BITS;
   localparam int NUM_REGS        = 6;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type REG_FF_COEF0 = csr_index_type'(0);
   localparam csr_index_type REG_FF_COEF1 = csr_index_type'(1);
   localparam csr_index_type REG_FF_COEF2 = csr_index_type'(2);
   localparam csr_index_type REG_OUT_GAIN = csr_index_type'(3);
   localparam csr_index_type REG_FB_COEF1 = csr_index_type'(4);
   localparam csr_index_type REG_FB_COEF2 = csr_index_type'(5);

   typedef logic signed [COEF_WIDTH-1:0] coef_type;

   localparam coef_type RST_FF_COEF0 = coef_type'(15075);
   localparam coef_type RST_FF_COEF1 = coef_type'(-30148);
   localparam coef_type RST_FF_COEF2 = coef_type'(15075);
   localparam coef_type RST_OUT_GAIN = coef_type'(16384);
   localparam coef_type RST_FB_COEF1 = coef_type'(-30043);
   localparam coef_type RST_FB_COEF2 = coef_type'(13869);

   typedef logic [2:0] step_type;

   localparam step_type STEP_FF0  = step_type'(0);
   localparam step_type STEP_FF1  = step_type'(1);
   localparam step_type STEP_FF2  = step_type'(2);
   localparam step_type STEP_FB1  = step_type'(3);
   localparam step_type STEP_FB2  = step_type'(4);
   localparam step_type STEP_GAIN = step_type'(5);
   localparam step_type STEP_LAST = step_type'(6);

endpackage

FILE: rtl/biquad_iir_filter_top.sv
// Top level of the biquad filter: one direct form 1 section on a shared multiplier.
//
// Usage: samples arrive on the req_ stream, one per transfer. req_tuser is the
// command (low filters the sample in req_tdata, high clears all histories) and
// req_tlast marks the last sample of a buffer. Each accepted sample yields
// exactly one transfer on the rsp_ stream: the filtered sample in rsp_tdata,
// the clipping flag in rsp_tuser and the copied buffer marker in rsp_tlast.
// Coefficients are written on the csr_ port, by index. The user must write them
// only while the block is idle; the block itself does not enforce this. A filter
// sample passes seven sequencer steps through the single 16 by 24 bit multiplier
// and its accumulator, then the final step for rounding, clipping and history
// update. A clear goes from idle straight to the final step. One sample is in
// work at a time: a new sample is accepted only once the block is back in idle.
// Reset loads the default high-pass coefficients, zeroes the histories and
// clears the result valid flag. If the receiver stalls, the result is held and
// the block accepts a new sample; that sample completes its arithmetic and then
// waits in the final step until the held result has been transferred.
module biquad_iir_filter_top (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic signed [bqf_pkg::SAMPLE_WIDTH-1:0]  req_tdata,  // sample_in
   input  logic                                     req_tuser,  // cmd
   input  logic                                     req_tlast,  // block_end
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic signed [bqf_pkg::SAMPLE_WIDTH-1:0]  rsp_tdata,  // sample_out
   output logic                                     rsp_tuser,  // saturated
   output logic                                     rsp_tlast,  // block_end_out
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  bqf_pkg::csr_index_type                   csr_index,
   input  bqf_pkg::coef_type                        csr_data
);

   localparam int SW = bqf_pkg::SAMPLE_WIDTH;
   localparam int HW = bqf_pkg::HIST_WIDTH;
   localparam int PW = bqf_pkg::PROD_WIDTH;
   localparam int AW = bqf_pkg::ACC_WIDTH;
   localparam int YW = bqf_pkg::Y_WIDTH;
   localparam int FB = bqf_pkg::COEF_FRAC_BITS;
   localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) << (FB - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_FINISH} state_type;

   state_type                   state_ff, state_in;
   bqf_pkg::step_type           step_ff, step_in;
   bqf_pkg::coef_type           ff_coef0_ff, ff_coef0_in;
   bqf_pkg::coef_type           ff_coef1_ff, ff_coef1_in;
   bqf_pkg::coef_type           ff_coef2_ff, ff_coef2_in;
   bqf_pkg::coef_type           out_gain_ff, out_gain_in;
   bqf_pkg::coef_type           fb_coef1_ff, fb_coef1_in;
   bqf_pkg::coef_type           fb_coef2_ff, fb_coef2_in;
   logic signed [SW-1:0]        x_ff, x_in;
   logic                        cmd_ff, cmd_in;
   logic                        last_ff, last_in;
   logic signed [SW-1:0]        x_hist1_ff, x_hist1_in;
   logic signed [SW-1:0]        x_hist2_ff, x_hist2_in;
   logic signed [HW-1:0]        y_hist1_ff, y_hist1_in;
   logic signed [HW-1:0]        y_hist2_ff, y_hist2_in;
   logic signed [HW-1:0]        center_ff, center_in;
   logic signed [PW-1:0]        prod_ff, prod_in;
   logic signed [AW-1:0]        acc_ff, acc_in;
   logic                        rsp_tvalid_ff, rsp_tvalid_in;
   logic signed [SW-1:0]        rsp_tdata_ff, rsp_tdata_in;
   logic                        rsp_tuser_ff, rsp_tuser_in;
   logic                        rsp_tlast_ff, rsp_tlast_in;

   bqf_pkg::coef_type           mul_a;
   logic signed [HW-1:0]        mul_b;
   logic signed [AW-1:0]        prod_ext;
   logic signed [AW-1:0]        acc_rnd;
   logic signed [YW-1:0]        y_val;
   logic                        hist_ok;
   logic                        samp_ok;
   logic signed [HW-1:0]        y_hist_clip;
   logic signed [SW-1:0]        y_out_clip;
   logic                        out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign prod_ext = AW'(prod_ff);
   assign acc_rnd  = acc_ff + ROUND_HALF;
   assign y_val    = acc_rnd[AW-1:FB];
   assign hist_ok  = (&y_val[YW-1:HW-1]) || !(|y_val[YW-1:HW-1]);
   assign samp_ok  = (&y_val[YW-1:SW-1]) || !(|y_val[YW-1:SW-1]);

   always_comb begin
      if (hist_ok) begin
         y_hist_clip = y_val[HW-1:0];
      end else if (y_val[YW-1]) begin
         y_hist_clip = {1'b1, {(HW-1){1'b0}}};
      end else begin
         y_hist_clip = {1'b0, {(HW-1){1'b1}}};
      end
      if (samp_ok) begin
         y_out_clip = y_val[SW-1:0];
      end else if (y_val[YW-1]) begin
         y_out_clip = {1'b1, {(SW-1){1'b0}}};
      end else begin
         y_out_clip = {1'b0, {(SW-1){1'b1}}};
      end
   end

   always_comb begin
      case (step_ff)
         bqf_pkg::STEP_FF0: begin
            mul_a = ff_coef0_ff;
            mul_b = HW'(x_ff);
         end
         bqf_pkg::STEP_FF1: begin
            mul_a = ff_coef1_ff;
            mul_b = HW'(x_hist1_ff);
         end
         bqf_pkg::STEP_FF2: begin
            mul_a = ff_coef2_ff;
            mul_b = HW'(x_hist2_ff);
         end
         bqf_pkg::STEP_FB1: begin
            mul_a = fb_coef1_ff;
            mul_b = y_hist1_ff;
         end
         bqf_pkg::STEP_FB2: begin
            mul_a = fb_coef2_ff;
            mul_b = y_hist2_ff;
         end
         bqf_pkg::STEP_GAIN: begin
            mul_a = out_gain_ff;
            mul_b = center_ff;
         end
         default: begin
            mul_a = ff_coef0_ff;
            mul_b = HW'(x_ff);
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      ff_coef0_in   = ff_coef0_ff;
      ff_coef1_in   = ff_coef1_ff;
      ff_coef2_in   = ff_coef2_ff;
      out_gain_in   = out_gain_ff;
      fb_coef1_in   = fb_coef1_ff;
      fb_coef2_in   = fb_coef2_ff;
      x_in          = x_ff;
      cmd_in        = cmd_ff;
      last_in       = last_ff;
      x_hist1_in    = x_hist1_ff;
      x_hist2_in    = x_hist2_ff;
      y_hist1_in    = y_hist1_ff;
      y_hist2_in    = y_hist2_ff;
      center_in     = center_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;

      if (csr_valid) begin
         unique case (csr_index)
            bqf_pkg::REG_FF_COEF0: ff_coef0_in = csr_data;
            bqf_pkg::REG_FF_COEF1: ff_coef1_in = csr_data;
            bqf_pkg::REG_FF_COEF2: ff_coef2_in = csr_data;
            bqf_pkg::REG_OUT_GAIN: out_gain_in = csr_data;
            bqf_pkg::REG_FB_COEF1: fb_coef1_in = csr_data;
            bqf_pkg::REG_FB_COEF2: fb_coef2_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               x_in     = req_tdata;
               cmd_in   = req_tuser;
               last_in  = req_tlast;
               step_in  = bqf_pkg::STEP_FF0;
               state_in = req_tuser ? ST_FINISH : ST_BUSY;
            end
         end
         ST_BUSY: begin
            prod_in = mul_a * mul_b;
            case (step_ff)
               bqf_pkg::STEP_FF1: acc_in = prod_ext;
               bqf_pkg::STEP_FF2,
               bqf_pkg::STEP_FB1,
               bqf_pkg::STEP_LAST: acc_in = acc_ff + prod_ext;
               bqf_pkg::STEP_FB2: begin
                  center_in = acc_rnd[FB +: HW];
                  acc_in    = -prod_ext;
               end
               bqf_pkg::STEP_GAIN: acc_in = acc_ff - prod_ext;
               default: ;
            endcase
            step_in = step_ff + bqf_pkg::step_type'(1);
            if (step_ff == bqf_pkg::STEP_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tlast_in  = last_ff;
               state_in      = ST_IDLE;
               if (cmd_ff) begin
                  rsp_tdata_in = '0;
                  rsp_tuser_in = 1'b0;
                  x_hist1_in   = '0;
                  x_hist2_in   = '0;
                  y_hist1_in   = '0;
                  y_hist2_in   = '0;
               end else begin
                  rsp_tdata_in = y_out_clip;
                  rsp_tuser_in = !(hist_ok && samp_ok);
                  x_hist1_in   = x_ff;
                  x_hist2_in   = x_hist1_ff;
                  y_hist1_in   = y_hist_clip;
                  y_hist2_in   = y_hist1_ff;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= bqf_pkg::STEP_FF0;
         ff_coef0_ff   <= bqf_pkg::RST_FF_COEF0;
         ff_coef1_ff   <= bqf_pkg::RST_FF_COEF1;
         ff_coef2_ff   <= bqf_pkg::RST_FF_COEF2;
         out_gain_ff   <= bqf_pkg::RST_OUT_GAIN;
         fb_coef1_ff   <= bqf_pkg::RST_FB_COEF1;
         fb_coef2_ff   <= bqf_pkg::RST_FB_COEF2;
         x_hist1_ff    <= '0;
         x_hist2_ff    <= '0;
         y_hist1_ff    <= '0;
         y_hist2_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         ff_coef0_ff   <= ff_coef0_in;
         ff_coef1_ff   <= ff_coef1_in;
         ff_coef2_ff   <= ff_coef2_in;
         out_gain_ff   <= out_gain_in;
         fb_coef1_ff   <= fb_coef1_in;
         fb_coef2_ff   <= fb_coef2_in;
         x_hist1_ff    <= x_hist1_in;
         x_hist2_ff    <= x_hist2_in;
         y_hist1_ff    <= y_hist1_in;
         y_hist2_ff    <= y_hist2_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      x_ff         <= x_in;
      cmd_ff       <= cmd_in;
      last_ff      <= last_in;
      center_ff    <= center_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUSY) |-> (step_ff <= bqf_pkg::STEP_LAST))
      else $error("Sequencer step beyond the last multiply step.");

   a_clear_skips_mul: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) |=> (state_ff == ST_FINISH))
      else $error("Clear command did not go straight to the final step.");

   a_finish_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> (rsp_tvalid_ff && state_ff == ST_IDLE))
      else $error("Final step did not load the result register.");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free && cmd_ff) |=>
      (x_hist1_ff == '0 && y_hist1_ff == '0 && rsp_tdata_ff == '0 && !rsp_tuser_ff))
      else $error("Clear command left a history or the result non-zero.");

endmodule

FILE: verif/biquad_iir_filter_top_tb.sv
// Self-checking testbench for the biquad filter top with a predicting scoreboard.
`timescale 1ns / 1ps

module biquad_iir_filter_top_tb;

   typedef logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [bqf_pkg::HIST_WIDTH-1:0]   hist_type;

   typedef struct {
      sample_type sample;
      logic       clipped;
      logic       last;
   } filter_result_type;

   localparam logic                   CMD_FILTER   = 1'b0;
   localparam logic                   CMD_CLEAR    = 1'b1;
   localparam bqf_pkg::csr_index_type IDX_SPARE_LO =
      bqf_pkg::csr_index_type'(bqf_pkg::NUM_REGS);
   localparam bqf_pkg::csr_index_type IDX_SPARE_HI = bqf_pkg::csr_index_type'(7);
   localparam int                     MAX_CYCLES   = 400000;
   localparam int                     PHASES       = 8;
   localparam int                     PHASE_ITEMS  = 156;

   class biquad_checker;
      bqf_pkg::coef_type coef [bqf_pkg::NUM_REGS];
      sample_type        x_d1, x_d2;
      hist_type          y_d1, y_d2;
      filter_result_type expected_q [$];
      int                errors, n_samples, n_clears, n_clipped, n_writes;

      function new();
         coef[bqf_pkg::REG_FF_COEF0] = bqf_pkg::RST_FF_COEF0;
         coef[bqf_pkg::REG_FF_COEF1] = bqf_pkg::RST_FF_COEF1;
         coef[bqf_pkg::REG_FF_COEF2] = bqf_pkg::RST_FF_COEF2;
         coef[bqf_pkg::REG_OUT_GAIN] = bqf_pkg::RST_OUT_GAIN;
         coef[bqf_pkg::REG_FB_COEF1] = bqf_pkg::RST_FB_COEF1;
         coef[bqf_pkg::REG_FB_COEF2] = bqf_pkg::RST_FB_COEF2;
         x_d1 = '0;
         x_d2 = '0;
         y_d1 = '0;
         y_d2 = '0;
      endfunction

      function longint round_q(longint v);
         return (v + (longint'(1) <<< (bqf_pkg::COEF_FRAC_BITS - 1)))
                >>> bqf_pkg::COEF_FRAC_BITS;
      endfunction

      function longint saturate(longint v, int w, inout logic hit);
         longint hi;
         hi = (longint'(1) <<< (w - 1)) - 1;
         if (v > hi) begin
            hit = 1'b1;
            return hi;
         end
         if (v < -hi - 1) begin
            hit = 1'b1;
            return -hi - 1;
         end
         return v;
      endfunction

      function void write_reg(bqf_pkg::csr_index_type idx, bqf_pkg::coef_type val);
         n_writes++;
         if (idx < bqf_pkg::NUM_REGS)
            coef[idx] = val;
      endfunction

      function void note_input(logic cmd, sample_type x, logic last);
         filter_result_type r;
         longint            acc, tap, y, yh, yo;
         logic              hit;
         r.last = last;
         if (cmd == CMD_CLEAR) begin
            x_d1 = '0;
            x_d2 = '0;
            y_d1 = '0;
            y_d2 = '0;
            r.sample = '0;
            r.clipped = 1'b0;
            n_clears++;
         end else begin
            hit = 1'b0;
            acc = longint'(coef[bqf_pkg::REG_FF_COEF0]) * longint'(x)
                + longint'(coef[bqf_pkg::REG_FF_COEF1]) * longint'(x_d1)
                + longint'(coef[bqf_pkg::REG_FF_COEF2]) * longint'(x_d2);
            tap = round_q(acc);
            acc = longint'(coef[bqf_pkg::REG_OUT_GAIN]) * tap
                - longint'(coef[bqf_pkg::REG_FB_COEF1]) * longint'(y_d1)
                - longint'(coef[bqf_pkg::REG_FB_COEF2]) * longint'(y_d2);
            y = round_q(acc);
            yh = saturate(y, bqf_pkg::HIST_WIDTH, hit);
            yo = saturate(y, bqf_pkg::SAMPLE_WIDTH, hit);
            x_d2 = x_d1;
            x_d1 = x;
            y_d2 = y_d1;
            y_d1 = hist_type'(yh);
            r.sample = sample_type'(yo);
            r.clipped = hit;
            n_samples++;
            if (hit)
               n_clipped++;
         end
         expected_q.push_back(r);
      endfunction

      function void check_result(sample_type sample, logic clipped, logic last);
         filter_result_type e;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result with nothing outstanding, expected none, got sample %0d",
                     $time, sample);
            return;
         end
         e = expected_q.pop_front();
         if (sample !== e.sample) begin
            errors++;
            $display("%0t: sample_out expected %0d, got %0d", $time, e.sample, sample);
         end
         if (clipped !== e.clipped) begin
            errors++;
            $display("%0t: saturated expected %0b, got %0b", $time, e.clipped, clipped);
         end
         if (last !== e.last) begin
            errors++;
            $display("%0t: block_end_out expected %0b, got %0b", $time, e.last, last);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   sample_type             req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   sample_type             rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   bqf_pkg::csr_index_type csr_index = '0;
   bqf_pkg::coef_type      csr_data = '0;

   biquad_checker sb;
   int            src_idle_pct = 0;
   int            sink_stall_pct = 0;
   int            holdoff_left = 0;
   int            cycle_count = 0;

   biquad_iir_filter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // sample_in
      .req_tuser  (req_tuser),   // cmd
      .req_tlast  (req_tlast),   // block_end
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // sample_out
      .rsp_tuser  (rsp_tuser),   // saturated
      .rsp_tlast  (rsp_tlast),   // block_end_out
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Transfers are observed with the values that held just before the edge.
   always @(posedge clock) begin
      if (!reset && sb != null) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
         if (req_tvalid && req_tready)
            sb.note_input(req_tuser, req_tdata, req_tlast);
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_data);
      end
   end

   // Receiver: random stalls, or a long hold-off while one is requested.
   initial begin : sink_proc
      forever begin
         @(posedge clock);
         if (holdoff_left > 0) begin
            rsp_tready <= 1'b0;
            holdoff_left = holdoff_left - 1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   task automatic send_item(logic cmd, sample_type x, logic last);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= x;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(bqf_pkg::csr_index_type idx, bqf_pkg::coef_type val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_filter(bqf_pkg::coef_type ff0, bqf_pkg::coef_type ff1,
                                 bqf_pkg::coef_type ff2, bqf_pkg::coef_type gain,
                                 bqf_pkg::coef_type fb1, bqf_pkg::coef_type fb2);
      write_reg(bqf_pkg::REG_FF_COEF0, ff0);
      write_reg(bqf_pkg::REG_FF_COEF1, ff1);
      write_reg(bqf_pkg::REG_FF_COEF2, ff2);
      write_reg(bqf_pkg::REG_OUT_GAIN, gain);
      write_reg(bqf_pkg::REG_FB_COEF1, fb1);
      write_reg(bqf_pkg::REG_FB_COEF2, fb2);
      csr_valid <= 1'b0;
   endtask

   // Waits for every outstanding result, then lets the sequencer return to idle.
   task automatic settle_filter();
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(7))
         0: begin
            case ($urandom_range(4))
               0: return sample_type'(32767);
               1: return sample_type'(-32768);
               2: return sample_type'(0);
               3: return sample_type'(1);
               default: return sample_type'(-1);
            endcase
         end
         1, 2: return sample_type'(int'($urandom_range(512)) - 256);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic bqf_pkg::coef_type pick_coef();
      case ($urandom_range(7))
         0: return bqf_pkg::coef_type'(-32768);
         1: return bqf_pkg::coef_type'(32767);
         2: return bqf_pkg::coef_type'(0);
         3: return bqf_pkg::coef_type'(16384);
         default: return bqf_pkg::coef_type'($urandom);
      endcase
   endfunction

   initial begin : main_seq
      int                p, i, mag;
      bqf_pkg::coef_type fb1, fb2;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default high-pass coefficients straight after reset.
      send_item(CMD_CLEAR, sample_type'(-32768), 1'b1);
      send_item(CMD_FILTER, sample_type'(32767), 1'b0);
      send_item(CMD_FILTER, sample_type'(-32768), 1'b0);
      send_item(CMD_FILTER, sample_type'(32767), 1'b0);
      send_item(CMD_FILTER, sample_type'(-32768), 1'b0);
      send_item(CMD_FILTER, sample_type'(0), 1'b0);
      send_item(CMD_FILTER, sample_type'(1), 1'b1);
      req_tvalid <= 1'b0;
      settle_filter();

      // Half gain on the current input only, so that rounding meets exact ties.
      write_reg(IDX_SPARE_LO, bqf_pkg::coef_type'(32767));
      write_reg(IDX_SPARE_HI, bqf_pkg::coef_type'(-32768));
      program_filter(bqf_pkg::coef_type'(8192), bqf_pkg::coef_type'(0),
                     bqf_pkg::coef_type'(0), bqf_pkg::coef_type'(16384),
                     bqf_pkg::coef_type'(0), bqf_pkg::coef_type'(0));
      send_item(CMD_FILTER, sample_type'(1), 1'b0);
      send_item(CMD_FILTER, sample_type'(-1), 1'b0);
      send_item(CMD_FILTER, sample_type'(3), 1'b0);
      send_item(CMD_FILTER, sample_type'(-3), 1'b1);
      send_item(CMD_CLEAR, sample_type'(12345), 1'b0);
      req_tvalid <= 1'b0;
      settle_filter();

      // Extreme gains with positive feedback drive both saturation limits.
      program_filter(bqf_pkg::coef_type'(32767), bqf_pkg::coef_type'(32767),
                     bqf_pkg::coef_type'(32767), bqf_pkg::coef_type'(32767),
                     bqf_pkg::coef_type'(-32768), bqf_pkg::coef_type'(-32768));
      repeat (5) send_item(CMD_FILTER, sample_type'(32767), 1'b0);
      send_item(CMD_CLEAR, sample_type'(0), 1'b1);
      repeat (3) send_item(CMD_FILTER, sample_type'(-32768), 1'b0);
      send_item(CMD_FILTER, sample_type'(-32768), 1'b1);
      req_tvalid <= 1'b0;
      settle_filter();

      for (p = 0; p < PHASES; p++) begin
         if (p % 2 == 0) begin
            // A stable section: poles kept inside the unit circle.
            fb2 = bqf_pkg::coef_type'($urandom_range(15000, 8192));
            mag = $urandom_range(8000 + int'(fb2), 0);
            fb1 = bqf_pkg::coef_type'($urandom_range(1) ? mag : -mag);
            program_filter(bqf_pkg::coef_type'(int'($urandom_range(24000)) - 12000),
                           bqf_pkg::coef_type'(int'($urandom_range(24000)) - 12000),
                           bqf_pkg::coef_type'(int'($urandom_range(24000)) - 12000),
                           bqf_pkg::coef_type'($urandom_range(24576, 8192)), fb1, fb2);
         end else begin
            program_filter(pick_coef(), pick_coef(), pick_coef(),
                           pick_coef(), pick_coef(), pick_coef());
         end
         case (p % 4)
            0: begin
               src_idle_pct = 0;
               sink_stall_pct = 0;
               holdoff_left = 300;
            end
            1: begin
               src_idle_pct = 49;
               sink_stall_pct = 0;
            end
            2: begin
               src_idle_pct = 0;
               sink_stall_pct = 49;
            end
            default: begin
               src_idle_pct = 16;
               sink_stall_pct = 16;
            end
         endcase
         for (i = 0; i < PHASE_ITEMS; i++)
            send_item(($urandom_range(31) == 0) ? CMD_CLEAR : CMD_FILTER,
                      pick_sample(), ($urandom_range(7) == 0));
         req_tvalid <= 1'b0;
         settle_filter();
      end

      repeat (20) @(posedge clock);
      $display("Run covered %0d filtered samples and %0d clears, %0d of them clipped.",
               sb.n_samples, sb.n_clears, sb.n_clipped);
      $display("Coefficient writes: %0d, over stable and extreme sections %s",
               sb.n_writes, "and four idling patterns.");
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: files.f
rtl/bqf_pkg.sv
rtl/biquad_iir_filter_top.sv
verif/biquad_iir_filter_top_tb.sv
